### design/pphq_pkg.sv
// Shared constants, types and codes of the prefix hash query block.
package pphq_pkg;

    localparam int unsigned MAX_LEN = 1024;
    localparam int unsigned ADDR_W  = $clog2(MAX_LEN);
    localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
    localparam int unsigned POS_W   = 10;
    localparam int unsigned CODE_W  = 7;
    localparam int unsigned HASH_W  = 30;
    localparam int unsigned CMP_W   = LEN_W + POS_W;

    localparam logic [HASH_W-1:0] HASH_MOD    = 30'd1000000007;
    localparam logic [HASH_W-1:0] HASH_BASE   = 30'd31;
    localparam logic [HASH_W-1:0] BASE_INV    = 30'd129032259;
    localparam logic [CODE_W-1:0] LETTER_BIAS = 7'd96;

    // Barrett factor floor(2^60 / p)
    localparam logic [30:0] BARRETT_M = 31'((64'd1 << 60) / 64'(HASH_MOD));

    typedef enum logic [1:0] {
        MT_HASH,
        MT_POW,
        MT_INV,
        MT_QRY
    } t_mtag;

    typedef struct packed {
        logic              valid;
        t_mtag             tag;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              valid;
        t_mtag             tag;
        logic [HASH_W-1:0] p;
    } t_mul_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APP,
        ST_APP_POW,
        ST_APP_INV,
        ST_QRY,
        ST_QRY_LO,
        ST_QRY_DIFF,
        ST_QRY_MUL,
        ST_WAIT,
        ST_DONE
    } t_state;

endpackage

### design/prefix_poly_hash_substring_query.sv
// Top level: polynomial prefix hash table with substring hash queries.
//
// Requests arrive on the s_axis channel: tuser is the mode (0 append a
// letter, 1 query a substring), tdata carries restart, letter code, left
// and right. Each request gives exactly one result on the m_axis channel:
// tdata holds the hash, tuser the error flag.
// An append stores the new prefix hash and inverse power of 31 in two
// 1024 x 30 RAMs and returns the prefix hash. A query reads prefix[right],
// prefix[left-1] and inverse[left] and returns their normalized difference.
// One request is processed at a time. Every valid request waits on the
// four-stage modular multiplier, and a valid query also on the two
// sequential reads of the prefix RAM; an invalid query or an append to a
// full table waits on neither and goes straight to its error result.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver still stalls when that request is done,
// the block holds it and accepts nothing more.
// Reset empties the table (length zero, running powers one); the RAMs
// are not cleared and need no clearing pass.
module prefix_poly_hash_substring_query import pphq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] restart, [7:1] letter_code, [17:8] left, [27:18] right, [31:28] zero
    input  logic [31:0] s_axis_tdata,
    // [0] mode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [29:0] hash_value, [31:30] zero
    output logic [31:0] m_axis_tdata,
    // [0] error
    output logic        m_axis_tuser
);

    t_state            r_state, n_state;
    logic [CODE_W-1:0] r_val;
    logic [POS_W-1:0]  r_left, r_right;
    logic [LEN_W-1:0]  r_len;
    logic [HASH_W-1:0] r_pow, r_inv, r_last;
    logic [HASH_W-1:0] r_hi, r_diff, r_invq;
    logic [HASH_W-1:0] r_res_hash;
    logic              r_res_err;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_hash;
    logic              r_out_err;

    t_mul_req          mul_req;
    t_mul_rsp          mul_rsp;
    logic              pre_we;
    logic [ADDR_W-1:0] pre_waddr, pre_raddr, inv_raddr;
    logic [HASH_W-1:0] pre_rdata, inv_rdata;
    logic              out_load;
    logic              in_fire;

    logic              full;
    logic              q_err;
    logic [HASH_W:0]   app_sum, app_red;
    logic [HASH_W-1:0] app_hash;
    logic [HASH_W-1:0] q_lo;
    logic [HASH_W:0]   q_sub, q_fix;
    logic [HASH_W-1:0] q_diff;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // datapath helpers
    always_comb begin
        full    = (r_len == LEN_W'(MAX_LEN));
        q_err   = (r_left > r_right)
               || (CMP_W'(r_right) >= CMP_W'(r_len))
               || (CMP_W'(r_right) >= CMP_W'(MAX_LEN));
        app_sum = {1'b0, ((r_len == '0) ? '0 : r_last)} + {1'b0, mul_rsp.p};
        app_red = app_sum - {1'b0, HASH_MOD};
        app_hash = (app_sum >= {1'b0, HASH_MOD}) ? app_red[HASH_W-1:0]
                                                 : app_sum[HASH_W-1:0];
        q_lo    = (r_left == '0) ? '0 : pre_rdata;
        q_sub   = {1'b0, r_hi} - {1'b0, q_lo};
        q_fix   = q_sub + {1'b0, HASH_MOD};
        q_diff  = q_sub[HASH_W] ? q_fix[HASH_W-1:0] : q_sub[HASH_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = s_axis_tuser ? ST_QRY : ST_APP;
                end
            end
            ST_APP:      n_state = full ? ST_DONE : ST_APP_POW;
            ST_APP_POW:  n_state = ST_APP_INV;
            ST_APP_INV:  n_state = ST_WAIT;
            ST_QRY:      n_state = q_err ? ST_DONE : ST_QRY_LO;
            ST_QRY_LO:   n_state = ST_QRY_DIFF;
            ST_QRY_DIFF: n_state = ST_QRY_MUL;
            ST_QRY_MUL:  n_state = ST_WAIT;
            ST_WAIT: begin
                if (mul_rsp.valid && (mul_rsp.tag == MT_INV || mul_rsp.tag == MT_QRY)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mul_req.valid = 1'b0;
        mul_req.tag   = MT_HASH;
        mul_req.a     = HASH_W'(r_val);
        mul_req.b     = r_pow;
        pre_we        = 1'b0;
        pre_raddr     = ADDR_W'(r_right);
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_APP:  mul_req.valid = !full;
            ST_APP_POW: begin
                mul_req.valid = 1'b1;
                mul_req.tag   = MT_POW;
                mul_req.a     = r_pow;
                mul_req.b     = HASH_BASE;
            end
            ST_APP_INV: begin
                mul_req.valid = 1'b1;
                mul_req.tag   = MT_INV;
                mul_req.a     = r_inv;
                mul_req.b     = BASE_INV;
            end
            ST_QRY_LO: pre_raddr = ADDR_W'(r_left - POS_W'(1));
            ST_QRY_MUL: begin
                mul_req.valid = 1'b1;
                mul_req.tag   = MT_QRY;
                mul_req.a     = r_diff;
                mul_req.b     = r_invq;
            end
            ST_WAIT: pre_we = mul_rsp.valid && (mul_rsp.tag == MT_HASH);
            ST_DONE: out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign pre_waddr = ADDR_W'(r_len);
    assign inv_raddr = ADDR_W'(r_left);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_pow       <= HASH_W'(1);
            r_inv       <= HASH_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire && !s_axis_tuser && s_axis_tdata[0]) begin
                r_len <= '0;
                r_pow <= HASH_W'(1);
                r_inv <= HASH_W'(1);
            end
            if (r_state == ST_WAIT && mul_rsp.valid) begin
                case (mul_rsp.tag)
                    MT_POW: r_pow <= mul_rsp.p;
                    MT_INV: begin
                        r_inv <= mul_rsp.p;
                        r_len <= r_len + LEN_W'(1);
                    end
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_val   <= s_axis_tdata[7:1] - LETTER_BIAS;
            r_left  <= s_axis_tdata[17:8];
            r_right <= s_axis_tdata[27:18];
        end
        if ((r_state == ST_APP && full) || (r_state == ST_QRY && q_err)) begin
            r_res_hash <= '0;
            r_res_err  <= 1'b1;
        end
        if (r_state == ST_QRY_LO) begin
            r_hi <= pre_rdata;
        end
        if (r_state == ST_QRY_DIFF) begin
            r_diff <= q_diff;
            r_invq <= inv_rdata;
        end
        if (r_state == ST_WAIT && mul_rsp.valid) begin
            if (mul_rsp.tag == MT_HASH) begin
                r_last     <= app_hash;
                r_res_hash <= app_hash;
                r_res_err  <= 1'b0;
            end else if (mul_rsp.tag == MT_QRY) begin
                r_res_hash <= mul_rsp.p;
                r_res_err  <= 1'b0;
            end
        end
        if (out_load) begin
            r_out_hash <= r_res_hash;
            r_out_err  <= r_res_err;
        end
    end

    pphq_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    pphq_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (pre_we),
        .i_waddr (pre_waddr),
        .i_wdata (app_hash),
        .i_raddr (pre_raddr),
        .o_rdata (pre_rdata)
    );

    pphq_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_inverse_ram (
        .i_clk   (i_clk),
        .i_we    (pre_we),
        .i_waddr (pre_waddr),
        .i_wdata (r_inv),
        .i_raddr (inv_raddr),
        .o_rdata (inv_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 32'(r_out_hash);
    assign m_axis_tuser  = r_out_err;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_LEN))
        else $error("table length beyond capacity");

    a_rsp_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.valid |-> r_state == ST_WAIT)
        else $error("multiplier result outside wait state");

    a_mul_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.valid |-> mul_rsp.p < HASH_MOD)
        else $error("multiplier result not reduced");

    a_store_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pre_we |-> (app_hash < HASH_MOD && !full))
        else $error("bad prefix store write");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_APP || r_state == ST_QRY))
        else $error("accepted request not dispatched");

endmodule

### design/pphq_ram.sv
// Generic simple dual-port RAM with registered read.
module pphq_ram #(
    parameter int unsigned WIDTH = 30,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/pphq_mulmod.sv
// Four-stage pipelined multiply modulo p with Barrett reduction.
module pphq_mulmod import pphq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic              r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    t_mtag             r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag;
    logic [59:0]       r_s1_prod;
    logic [30:0]       r_s2_q;
    logic [31:0]       r_s2_xlo;
    logic [31:0]       r_s3_qp;
    logic [31:0]       r_s3_xlo;
    logic [HASH_W-1:0] r_s4_p;

    logic [61:0]       qm;
    logic [60:0]       qp;
    logic [31:0]       rem, rem1, rem2;
    logic [HASH_W-1:0] n_s4_p;

    always_comb begin
        qm   = 62'(r_s1_prod[59:29]) * 62'(BARRETT_M);
        qp   = 61'(r_s2_q) * 61'(HASH_MOD);
        rem  = r_s3_xlo - r_s3_qp;
        rem1 = rem - 32'(HASH_MOD);
        rem2 = rem - {1'b0, HASH_MOD, 1'b0};
        // estimate leaves at most two extra multiples of p
        if (rem >= {1'b0, HASH_MOD, 1'b0}) begin
            n_s4_p = rem2[HASH_W-1:0];
        end else if (rem >= 32'(HASH_MOD)) begin
            n_s4_p = rem1[HASH_W-1:0];
        end else begin
            n_s4_p = rem[HASH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tag  <= i_req.tag;
        r_s1_prod <= 60'(i_req.a) * 60'(i_req.b);
        r_s2_tag  <= r_s1_tag;
        r_s2_q    <= qm[61:31];
        r_s2_xlo  <= r_s1_prod[31:0];
        r_s3_tag  <= r_s2_tag;
        r_s3_qp   <= qp[31:0];
        r_s3_xlo  <= r_s2_xlo;
        r_s4_tag  <= r_s3_tag;
        r_s4_p    <= n_s4_p;
    end

    assign o_rsp.valid = r_s4_valid;
    assign o_rsp.tag   = r_s4_tag;
    assign o_rsp.p     = r_s4_p;

endmodule

### tb/sv/hash_checker.sv
// Request codes shared by the testbench, and the checker that predicts and compares results.
package hash_tb_pkg;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

endpackage

module hash_checker
    import pphq_pkg::*;
    import hash_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    // [0] restart, [7:1] letter_code, [17:8] left, [27:18] right, [31:28] zero
    input  logic [31:0] i_s_axis_tdata,
    // [0] mode
    input  logic        i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [29:0] hash_value, [31:30] zero
    input  logic [31:0] i_m_axis_tdata,
    // [0] error
    input  logic        i_m_axis_tuser,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic              err;
    } t_hash_rsp;

    logic [HASH_W-1:0] prefix_tab [MAX_LEN];
    logic [HASH_W-1:0] inv_tab    [MAX_LEN];
    logic [LEN_W-1:0]  str_len;
    logic [HASH_W-1:0] run_pow;
    logic [HASH_W-1:0] run_inv;

    t_hash_rsp expected_hashes [$];
    t_hash_rsp got;
    t_hash_rsp want;
    int        fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [HASH_W-1:0] mod_mul(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b);
        logic [63:0] prod;
        prod = 64'(a) * 64'(b);
        return HASH_W'(prod % 64'(HASH_MOD));
    endfunction

    function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b);
        logic [63:0] total;
        total = 64'(a) + 64'(b);
        return HASH_W'(total % 64'(HASH_MOD));
    endfunction

    // Apply one request to the shadow table and return the hash it yields.
    function automatic t_hash_rsp predict_hash(input logic              mode,
                                               input logic              restart,
                                               input logic [CODE_W-1:0] code,
                                               input logic [POS_W-1:0]  left,
                                               input logic [POS_W-1:0]  right);
        t_hash_rsp         rsp;
        logic [CODE_W-1:0] val;
        logic [HASH_W-1:0] prev;
        logic [HASH_W-1:0] diff;
        rsp = '0;
        if (mode == MODE_APPEND) begin
            if (restart) begin
                str_len = '0;
                run_pow = HASH_W'(1);
                run_inv = HASH_W'(1);
            end
            if (str_len >= LEN_W'(MAX_LEN)) begin
                rsp.err = 1'b1;
            end else begin
                // letters outside a..z wrap to 7 bits and are used as they are
                val      = code - LETTER_BIAS;
                prev     = (str_len != '0) ? prefix_tab[ADDR_W'(str_len - 1'b1)] : '0;
                rsp.hash = mod_add(prev, mod_mul(HASH_W'(val), run_pow));
                prefix_tab[str_len[ADDR_W-1:0]] = rsp.hash;
                inv_tab[str_len[ADDR_W-1:0]]    = run_inv;
                str_len  = str_len + 1'b1;
                run_pow  = mod_mul(run_pow, HASH_BASE);
                run_inv  = mod_mul(run_inv, BASE_INV);
            end
        end else begin
            if (left > right || LEN_W'(right) >= str_len) begin
                rsp.err = 1'b1;
            end else begin
                diff = prefix_tab[right];
                if (left != '0) begin
                    diff = mod_add(diff, HASH_MOD - prefix_tab[left - 1'b1]);
                end
                rsp.hash = mod_mul(diff, inv_tab[left]);
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            str_len = '0;
            run_pow = HASH_W'(1);
            run_inv = HASH_W'(1);
            expected_hashes.delete();
        end else begin
            // retire the result first; no request can be answered in its own cycle
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.hash = i_m_axis_tdata[HASH_W-1:0];
                got.err  = i_m_axis_tuser;
                if (expected_hashes.size() == 0) begin
                    $error("unexpected result: hash_value %0d error %0b", got.hash, got.err);
                    fails++;
                end else begin
                    want = expected_hashes.pop_front();
                    if (got.hash !== want.hash) begin
                        $error("hash_value mismatch: expected %0d, actual %0d",
                               want.hash, got.hash);
                        fails++;
                    end
                    if (got.err !== want.err) begin
                        $error("error mismatch: expected %0b, actual %0b", want.err, got.err);
                        fails++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_hashes.push_back(predict_hash(i_s_axis_tuser, i_s_axis_tdata[0],
                                                       i_s_axis_tdata[7:1],
                                                       i_s_axis_tdata[17:8],
                                                       i_s_axis_tdata[27:18]));
            end
        end
        o_pending    <= expected_hashes.size();
        o_fail_count <= fails;
    end

endmodule

### tb/sv/testbench.sv
// Top of the testbench: clock, reset, request stimulus, result back-pressure and verdict.
module testbench;

    import pphq_pkg::*;
    import hash_tb_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 30;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    int fail_count;
    int pending;
    int idle_count = 0;
    int built_len  = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit rx_hold_req = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    prefix_poly_hash_substring_query dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    hash_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Result side: random stalls, plus one long hold when asked.
    initial begin
        int gap;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                gap = HOLD_CYCLES;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                gap = $urandom_range(1, 14);
            end else begin
                m_axis_tready <= 1'b1;
                gap = 1;
            end
            repeat (gap) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one request and hold it until accepted; track the string length.
    task automatic send_request(input bit mode, input bit restart, input bit [6:0] code,
                                input bit [9:0] left, input bit [9:0] right);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'b0000, right, left, code, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        if (mode == MODE_APPEND) begin
            if (restart) built_len = 0;
            if (built_len < MAX_LEN) built_len++;
        end
    endtask

    function automatic bit [6:0] random_letter();
        if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(97, 122));
    endfunction

    task automatic send_valid_query();
        int l;
        int r;
        if (built_len == 0) begin
            send_request(MODE_QUERY, 1'($urandom), random_letter(),
                         10'($urandom), 10'($urandom));
        end else begin
            l = $urandom_range(0, built_len - 1);
            r = $urandom_range(built_len - 1, l);
            send_request(MODE_QUERY, 1'($urandom), 7'($urandom), 10'(l), 10'(r));
        end
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            send_request(MODE_APPEND, $urandom_range(0, 39) == 0, random_letter(),
                         10'($urandom), 10'($urandom));
        end else if (pick < 90) begin
            send_valid_query();
        end else begin
            send_request(MODE_QUERY, 1'($urandom), 7'($urandom),
                         10'($urandom), 10'($urandom));
        end
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, extreme letters, wrapped letters, ranges at and past the end
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd0,    10'd0);
        send_request(MODE_APPEND, 1'b0, 7'd97,  10'd1023, 10'd1023);
        send_request(MODE_APPEND, 1'b0, 7'd122, 10'd0,    10'd0);
        send_request(MODE_APPEND, 1'b0, 7'd0,   10'd0,    10'd0);
        send_request(MODE_APPEND, 1'b0, 7'd127, 10'd1023, 10'd0);
        send_request(MODE_APPEND, 1'b0, 7'd96,  10'd0,    10'd1023);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd0,    10'd0);
        send_request(MODE_QUERY,  1'b0, 7'd127, 10'd0,    10'd4);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd4,    10'd4);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd1,    10'd3);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd3,    10'd1);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd0,    10'd5);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd1023, 10'd1023);
        send_request(MODE_QUERY,  1'b1, 7'd0,   10'd0,    10'd1023);
        send_request(MODE_QUERY,  1'b1, 7'd0,   10'd2,    10'd4);
        // restart leaves stale entries that must not be readable
        send_request(MODE_APPEND, 1'b1, 7'd109, 10'd0,    10'd0);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd0,    10'd0);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd1,    10'd1);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd0,    10'd1);
        send_request(MODE_APPEND, 1'b1, 7'd127, 10'd0,    10'd0);
        send_request(MODE_APPEND, 1'b0, 7'd122, 10'd0,    10'd0);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd1,    10'd1);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd0,    10'd1);

        for (int i = 0; i < 400; i++) begin
            if (i == 150) rx_hold_req = 1'b1;
            if (i == 300) pause_until_drained();
            send_random_item();
        end

        // grow the string to the full table, then push past it
        while (built_len < MAX_LEN) begin
            if ($urandom_range(0, 4) == 0) begin
                send_valid_query();
            end else begin
                send_request(MODE_APPEND, 1'b0, random_letter(),
                             10'($urandom), 10'($urandom));
            end
        end
        send_request(MODE_APPEND, 1'b0, 7'd97,  10'd0,    10'd0);
        send_request(MODE_APPEND, 1'b0, 7'd122, 10'd1023, 10'd1023);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd0,    10'd1023);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd1023, 10'd1023);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd512,  10'd1023);
        send_request(MODE_QUERY,  1'b0, 7'd0,   10'd1022, 10'd1023);
        for (int i = 0; i < 10; i++) send_valid_query();
        send_request(MODE_APPEND, 1'b1, random_letter(), 10'd0, 10'd0);

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < 300; i++) send_random_item();

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
design/pphq_pkg.sv
design/pphq_ram.sv
design/pphq_mulmod.sv
design/prefix_poly_hash_substring_query.sv
tb/sv/hash_checker.sv
tb/sv/testbench.sv
